### sv/lrf_pkg.sv
// Shared types and constants for the LCD rectangle fill streamer.
// Holds the request and result structs, the stream phase enum and command codes.
// No dependencies; the register file, clipper, engine, top level and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

    // Largest panel side that the clipping logic supports by default.
    localparam int MAX_SIDE_DEF = 1024;

    // Panel controller command bytes.
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // Configuration register reset values and register map.
    localparam int          PANEL_REG_W      = 11;
    localparam logic [10:0] PANEL_W_RESET    = 11'd240;
    localparam logic [10:0] PANEL_H_RESET    = 11'd320;
    localparam int          CFG_ADDR_W       = 3;
    localparam logic [0:0]  REG_PANEL_WIDTH  = 1'b0;
    localparam logic [0:0]  REG_PANEL_HEIGHT = 1'b1;

    // Input item kinds.
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    // Stream phases; the window data phases are consecutive codes.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_COL_CMD = 4'd1,
        PH_COL_D0  = 4'd2,
        PH_COL_D1  = 4'd3,
        PH_COL_D2  = 4'd4,
        PH_COL_D3  = 4'd5,
        PH_ROW_CMD = 4'd6,
        PH_ROW_D0  = 4'd7,
        PH_ROW_D1  = 4'd8,
        PH_ROW_D2  = 4'd9,
        PH_ROW_D3  = 4'd10,
        PH_MEM_CMD = 4'd11,
        PH_PIXELS  = 4'd12
    } t_phase;

    // Panel size registers as seen by the datapath.
    typedef struct packed {
        logic [PANEL_REG_W-1:0] width;
        logic [PANEL_REG_W-1:0] height;
    } t_panel_cfg;

    // One input item.
    typedef struct packed {
        logic               kind;
        logic signed [15:0] origin_col;
        logic signed [15:0] origin_row;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [15:0]        fill_color;
    } t_req;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [7:0]  spi_byte;
        logic        is_data;
        logic        release_select;
        logic        fill_done;
    } t_res;

endpackage

`default_nettype wire

### sv/lrf_if.sv
// Stream channel interfaces for the LCD rectangle fill streamer.
// lrf_req_if carries requests and ticks, lrf_res_if carries result items.
// Depends on nothing; the handshake is valid/ready on both channels.
`timescale 1ns / 1ps
`default_nettype none

interface lrf_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] origin_col;
    logic signed [15:0] origin_row;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [15:0]        fill_color;

    modport source (
        output valid, kind, origin_col, origin_row, rect_width, rect_height, fill_color,
        input  ready
    );
    modport sink (
        input  valid, kind, origin_col, origin_row, rect_width, rect_height, fill_color,
        output ready
    );
endinterface

interface lrf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] spi_byte;
    logic       is_data;
    logic       release_select;
    logic       fill_done;

    modport source (
        output valid, status, spi_byte, is_data, release_select, fill_done,
        input  ready
    );
    modport sink (
        input  valid, status, spi_byte, is_data, release_select, fill_done,
        output ready
    );
endinterface

`default_nettype wire

### sv/lrf_cfg_regs.sv
// APB-style register file holding the panel width and height used for clipping.
// Depends on lrf_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module lrf_cfg_regs import lrf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output t_panel_cfg                 o_panel
);

    logic [PANEL_REG_W-1:0] r_panel_width;
    logic [PANEL_REG_W-1:0] r_panel_height;
    logic [0:0]             w_index;
    logic                   w_write;

    // Registers sit on 32-bit words; the word index picks the register.
    assign w_index = paddr[CFG_ADDR_W-1:2];
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register write in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width  <= PANEL_W_RESET;
            r_panel_height <= PANEL_H_RESET;
        end else if (w_write) begin
            case (w_index)
                REG_PANEL_WIDTH:  r_panel_width  <= pwdata[PANEL_REG_W-1:0];
                REG_PANEL_HEIGHT: r_panel_height <= pwdata[PANEL_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (w_index)
            REG_PANEL_WIDTH:  prdata = 32'(r_panel_width);
            REG_PANEL_HEIGHT: prdata = 32'(r_panel_height);
            default:          prdata = '0;
        endcase
    end

    assign o_panel.width  = r_panel_width;
    assign o_panel.height = r_panel_height;

endmodule

`default_nettype wire

### sv/lrf_clip.sv
// Combinational clipping of one fill request against the panel size.
// Produces the reject flag, the clipped size and the address window ends.
// Depends on lrf_pkg for the panel configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module lrf_clip import lrf_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic signed [15:0] i_origin_col,
    input  wire logic signed [15:0] i_origin_row,
    input  wire logic signed [15:0] i_rect_width,
    input  wire logic signed [15:0] i_rect_height,
    input  wire t_panel_cfg          i_panel,
    output logic                     o_reject,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_col_start,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_col_end,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_row_start,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_row_end,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_clip_w,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_clip_h
);

    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [SW-1:0] w_pw;
    logic [SW-1:0] w_ph;
    logic          w_col_bad;
    logic          w_row_bad;
    logic          w_col_over;
    logic          w_row_over;
    logic [SW-1:0] w_x;
    logic [SW-1:0] w_y;
    logic          w_single;

    // Panel size saturated to the largest supported side.
    assign w_pw = ({21'd0, i_panel.width}  > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(i_panel.width);
    assign w_ph = ({21'd0, i_panel.height} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(i_panel.height);

    // Negative or off-panel origin, or an empty or negative size, rejects the request.
    assign w_col_bad = i_origin_col[15] || (i_origin_col >= $signed({1'b0, 15'(w_pw)}))
                       || i_rect_width[15] || (i_rect_width == 16'sd0);
    assign w_row_bad = i_origin_row[15] || (i_origin_row >= $signed({1'b0, 15'(w_ph)}))
                       || i_rect_height[15] || (i_rect_height == 16'sd0);
    assign o_reject  = w_col_bad || w_row_bad;

    // The origin is below the panel size here, so it fits the side width.
    assign w_x = i_origin_col[SW-1:0];
    assign w_y = i_origin_row[SW-1:0];

    // Trim to the panel edge where the rectangle runs past it.
    assign w_col_over = ({1'b0, i_origin_col} + {1'b0, i_rect_width}) > 17'(w_pw);
    assign w_row_over = ({1'b0, i_origin_row} + {1'b0, i_rect_height}) > 17'(w_ph);
    assign o_clip_w   = w_col_over ? (w_pw - w_x) : i_rect_width[SW-1:0];
    assign o_clip_h   = w_row_over ? (w_ph - w_y) : i_rect_height[SW-1:0];

    // A single pixel keeps a window one step wider in both directions.
    assign w_single    = (o_clip_w == SW'(1)) && (o_clip_h == SW'(1));
    assign o_col_start = w_x;
    assign o_row_start = w_y;
    assign o_col_end   = w_single ? (w_x + SW'(1)) : (w_x + o_clip_w - SW'(1));
    assign o_row_end   = w_single ? (w_y + SW'(1)) : (w_y + o_clip_h - SW'(1));

endmodule

`default_nettype wire

### sv/lrf_engine.sv
// Stream engine: input register, phase sequencer and result register.
// Clips requests through lrf_clip and emits one byte per tick while a stream is running.
// Depends on lrf_pkg, lrf_if and lrf_clip.
`timescale 1ns / 1ps
`default_nettype none

module lrf_engine import lrf_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_panel_cfg i_panel,
    lrf_req_if.sink     i_req,
    lrf_res_if.source   o_res
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = 2 * SW;

    // Input stage.
    logic          r_in_valid;
    t_req          r_in;
    logic          w_advance;

    // Stream state.
    t_phase        r_phase;
    t_phase        n_phase;
    logic          r_low_next;
    logic          n_low_next;
    logic          r_load;
    logic [PW-1:0] r_pixels;
    logic [PW-1:0] n_pixels;
    logic [PW-1:0] w_pix_dec;
    logic [SW-1:0] r_col_start;
    logic [SW-1:0] r_col_end;
    logic [SW-1:0] r_row_start;
    logic [SW-1:0] r_row_end;
    logic [SW-1:0] r_clip_w;
    logic [SW-1:0] r_clip_h;
    logic [15:0]   r_color;

    // Result stage.
    logic          r_out_valid;
    logic          n_out_valid;
    t_res          r_res;
    t_res          n_res;
    logic          w_take;

    // Clipper outputs.
    logic          w_reject;
    logic [SW-1:0] w_col_start;
    logic [SW-1:0] w_col_end;
    logic [SW-1:0] w_row_start;
    logic [SW-1:0] w_row_end;
    logic [SW-1:0] w_clip_w;
    logic [SW-1:0] w_clip_h;

    // One byte of a window, start high and low, then end high and low.
    function automatic logic [7:0] win_byte(input logic [15:0] s, input logic [15:0] e,
                                            input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = s[15:8];
            2'd1:    b = s[7:0];
            2'd2:    b = e[15:8];
            default: b = e[7:0];
        endcase
        return b;
    endfunction

    // The held item moves on when the result register is free or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= '{kind:        i_req.kind,
                      origin_col:  i_req.origin_col,
                      origin_row:  i_req.origin_row,
                      rect_width:  i_req.rect_width,
                      rect_height: i_req.rect_height,
                      fill_color:  i_req.fill_color};
        end
    end

    lrf_clip #(
        .MAX_SIDE (MAX_SIDE)
    ) u_clip (
        .i_origin_col  (r_in.origin_col),
        .i_origin_row  (r_in.origin_row),
        .i_rect_width  (r_in.rect_width),
        .i_rect_height (r_in.rect_height),
        .i_panel       (i_panel),
        .o_reject      (w_reject),
        .o_col_start   (w_col_start),
        .o_col_end     (w_col_end),
        .o_row_start   (w_row_start),
        .o_row_end     (w_row_end),
        .o_clip_w      (w_clip_w),
        .o_clip_h      (w_clip_h)
    );

    assign w_pix_dec = (r_pixels != '0) ? (r_pixels - PW'(1)) : r_pixels;

    // Next state and result for the held item.
    always_comb begin
        n_phase    = r_phase;
        n_low_next = r_low_next;
        n_pixels   = r_pixels;
        n_out_valid = 1'b0;
        w_take     = 1'b0;
        n_res      = '{status: ST_BYTE, spi_byte: 8'd0, is_data: 1'b0,
                       release_select: 1'b0, fill_done: 1'b0};

        if (r_in.kind == KIND_FILL) begin
            n_out_valid = 1'b1;
            if (r_phase != PH_IDLE) begin
                n_res.status = ST_BUSY;
            end else if (w_reject) begin
                n_res.status = ST_REJECTED;
            end else begin
                n_res.status = ST_ACCEPTED;
                n_phase      = PH_COL_CMD;
                n_low_next   = 1'b0;
                w_take       = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_COL_CMD: begin
                    n_out_valid          = 1'b1;
                    n_res.spi_byte       = CMD_COL_SET;
                    n_res.release_select = 1'b1;
                    n_phase              = PH_COL_D0;
                end
                PH_COL_D0, PH_COL_D1, PH_COL_D2, PH_COL_D3: begin
                    n_out_valid    = 1'b1;
                    n_res.is_data  = 1'b1;
                    n_res.spi_byte = win_byte(16'(r_col_start), 16'(r_col_end),
                                              2'(r_phase - PH_COL_D0));
                    n_phase = (r_phase == PH_COL_D3) ? PH_ROW_CMD
                                                     : t_phase'(r_phase + 4'd1);
                end
                PH_ROW_CMD: begin
                    n_out_valid          = 1'b1;
                    n_res.spi_byte       = CMD_ROW_SET;
                    n_res.release_select = 1'b1;
                    n_phase              = PH_ROW_D0;
                end
                PH_ROW_D0, PH_ROW_D1, PH_ROW_D2, PH_ROW_D3: begin
                    n_out_valid    = 1'b1;
                    n_res.is_data  = 1'b1;
                    n_res.spi_byte = win_byte(16'(r_row_start), 16'(r_row_end),
                                              2'(r_phase - PH_ROW_D0));
                    n_phase = (r_phase == PH_ROW_D3) ? PH_MEM_CMD
                                                     : t_phase'(r_phase + 4'd1);
                end
                PH_MEM_CMD: begin
                    n_out_valid          = 1'b1;
                    n_res.spi_byte       = CMD_MEM_WRITE;
                    n_res.release_select = 1'b1;
                    n_low_next           = 1'b0;
                    n_phase              = PH_PIXELS;
                end
                PH_PIXELS: begin
                    n_out_valid   = 1'b1;
                    n_res.is_data = 1'b1;
                    if (!r_low_next) begin
                        n_res.spi_byte = r_color[15:8];
                        n_low_next     = 1'b1;
                    end else begin
                        n_res.spi_byte = r_color[7:0];
                        n_low_next     = 1'b0;
                        n_pixels       = w_pix_dec;
                        // Last low byte closes the fill and releases select.
                        if (w_pix_dec == '0) begin
                            n_phase              = PH_IDLE;
                            n_res.release_select = 1'b1;
                            n_res.fill_done      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Control state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_low_next  <= 1'b0;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_load <= w_advance && w_take;
            if (w_advance) begin
                r_phase     <= n_phase;
                r_low_next  <= n_low_next;
                r_out_valid <= n_out_valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window, color and result payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= n_res;
        end
        if (w_advance && w_take) begin
            r_col_start <= w_col_start;
            r_col_end   <= w_col_end;
            r_row_start <= w_row_start;
            r_row_end   <= w_row_end;
            r_clip_w    <= w_clip_w;
            r_clip_h    <= w_clip_h;
            r_color     <= r_in.fill_color;
        end
    end

    // The pixel count is formed from the registered clipped size while r_load is
    // set after the request is taken, well before the pixel phase needs it.
    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_pixels <= PW'(r_clip_w) * PW'(r_clip_h);
        end else if (w_advance) begin
            r_pixels <= n_pixels;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_res.status;
    assign o_res.spi_byte       = r_res.spi_byte;
    assign o_res.is_data        = r_res.is_data;
    assign o_res.release_select = r_res.release_select;
    assign o_res.fill_done      = r_res.fill_done;

    // A fill always ends on a data byte that also releases select.
    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.fill_done) |-> (r_res.release_select && r_res.is_data))
        else $error("fill_done without release_select on a data byte");

    // Status results carry no byte.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status != ST_BYTE)) |->
        ((r_res.spi_byte == 8'd0) && !r_res.is_data && !r_res.fill_done))
        else $error("status result carries byte fields");

    // The pixel phase never runs with an exhausted count.
    a_pixels_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (r_pixels != '0))
        else $error("pixel phase with zero pixels left");

    // A request during a stream is refused and leaves the phase alone.
    a_busy_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in.kind == KIND_FILL) && (r_phase != PH_IDLE)) |=>
        (r_out_valid && (r_res.status == ST_BUSY) && $stable(r_phase)))
        else $error("busy request not refused");

endmodule

`default_nettype wire

### sv/lcd_rect_fill_streamer_top.sv
// Top level of the LCD rectangle fill streamer.
// Connects the APB register file and the stream engine.
// Depends on lrf_pkg, lrf_if, lrf_cfg_regs, lrf_clip and lrf_engine.
//
//   Channel   Direction  Handshake               Contents
//   i_req     in         valid/ready             kind, origin, size, fill_color
//   o_res     out        valid/ready             status, spi_byte, flags
//   APB       in         psel/penable, pready=1  panel_width, panel_height
//
// One item is taken per cycle while the result register is not stalled; its result
// is loaded into the result register once the item has passed the input register
// and the phase sequencer. Reset is synchronous and active low, clears the phase
// and the valid flags, and sets the panel size registers to their reset values.
// A stalled result holds the item behind it in the input register.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rect_fill_streamer_top import lrf_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lrf_req_if.sink                    i_req,
    lrf_res_if.source                  o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_panel_cfg w_panel;

    // Panel size registers.
    lrf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_panel (w_panel)
    );

    // Clipping and byte stream generation.
    lrf_engine #(
        .MAX_SIDE (MAX_SIDE)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_panel (w_panel),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### tb/lcd_rect_fill_streamer_top_tb.sv
// Self-checking testbench for the LCD rectangle fill streamer top level.
// Drives fill requests and ticks, predicts every result item and checks them in order.
// Depends on lrf_pkg, lrf_if and lcd_rect_fill_streamer_top.
`timescale 1ns / 1ps

module lcd_rect_fill_streamer_top_tb;
    import lrf_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    lrf_req_if req_if();
    lrf_res_if res_if();

    lcd_rect_fill_streamer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Items waiting to be offered, and result items still due from the block.
    t_req pending_items[$];
    t_res results_due[$];

    int errors        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit req_fire      = 1'b0;
    bit stall_armed   = 1'b0;
    bit stall_done    = 1'b0;
    int stall_left    = 0;

    // Shadow copy of the panel registers and the stream state.
    logic [10:0] shadow_width  = PANEL_W_RESET;
    logic [10:0] shadow_height = PANEL_H_RESET;
    t_phase      stream_phase  = PH_IDLE;
    logic [15:0] win_col_lo    = '0;
    logic [15:0] win_col_hi    = '0;
    logic [15:0] win_row_lo    = '0;
    logic [15:0] win_row_hi    = '0;
    logic [15:0] pixel_color   = '0;
    logic [20:0] pixels_todo   = '0;
    logic        color_low_due = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Picks one byte of a window start/end pair, high byte first.
    function automatic logic [7:0] window_byte(input logic [15:0] lo, input logic [15:0] hi,
                                               input logic [1:0] idx);
        case (idx)
            2'd0:    return lo[15:8];
            2'd1:    return lo[7:0];
            2'd2:    return hi[15:8];
            default: return hi[7:0];
        endcase
    endfunction

    // Advances the stream state by one accepted item; returns 1 when a result is due.
    function automatic bit predict_stream(input t_req it, output t_res exp_res);
        int x, y, w, h, pw, ph;
        exp_res = '0;
        exp_res.status = ST_BYTE;
        if (it.kind == KIND_FILL) begin
            if (stream_phase != PH_IDLE) begin
                exp_res.status = ST_BUSY;
                return 1'b1;
            end
            x  = $signed(it.origin_col);
            y  = $signed(it.origin_row);
            w  = $signed(it.rect_width);
            h  = $signed(it.rect_height);
            pw = (shadow_width > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(shadow_width);
            ph = (shadow_height > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(shadow_height);
            if (x < 0 || y < 0 || x >= pw || y >= ph || w < 1 || h < 1) begin
                exp_res.status = ST_REJECTED;
                return 1'b1;
            end
            if (x + w - 1 >= pw) w = pw - x;
            if (y + h - 1 >= ph) h = ph - y;
            win_col_lo = 16'(x);
            win_row_lo = 16'(y);
            // A single pixel keeps a window one wider and one taller.
            if (w == 1 && h == 1) begin
                win_col_hi = 16'(x + 1);
                win_row_hi = 16'(y + 1);
            end else begin
                win_col_hi = 16'(x + w - 1);
                win_row_hi = 16'(y + h - 1);
            end
            pixel_color   = it.fill_color;
            pixels_todo   = 21'(w * h);
            color_low_due = 1'b0;
            stream_phase  = PH_COL_CMD;
            exp_res.status = ST_ACCEPTED;
            return 1'b1;
        end

        case (stream_phase)
            PH_IDLE: begin
                return 1'b0;
            end
            PH_COL_CMD: begin
                stream_phase = PH_COL_D0;
                exp_res.spi_byte = CMD_COL_SET;
                exp_res.release_select = 1'b1;
            end
            PH_COL_D0, PH_COL_D1, PH_COL_D2, PH_COL_D3: begin
                exp_res.spi_byte = window_byte(win_col_lo, win_col_hi,
                                               2'(stream_phase - PH_COL_D0));
                exp_res.is_data = 1'b1;
                stream_phase = t_phase'(stream_phase + 4'd1);
            end
            PH_ROW_CMD: begin
                stream_phase = PH_ROW_D0;
                exp_res.spi_byte = CMD_ROW_SET;
                exp_res.release_select = 1'b1;
            end
            PH_ROW_D0, PH_ROW_D1, PH_ROW_D2, PH_ROW_D3: begin
                exp_res.spi_byte = window_byte(win_row_lo, win_row_hi,
                                               2'(stream_phase - PH_ROW_D0));
                exp_res.is_data = 1'b1;
                stream_phase = t_phase'(stream_phase + 4'd1);
            end
            PH_MEM_CMD: begin
                stream_phase = PH_PIXELS;
                color_low_due = 1'b0;
                exp_res.spi_byte = CMD_MEM_WRITE;
                exp_res.release_select = 1'b1;
            end
            PH_PIXELS: begin
                exp_res.is_data = 1'b1;
                if (!color_low_due) begin
                    color_low_due = 1'b1;
                    exp_res.spi_byte = pixel_color[15:8];
                end else begin
                    color_low_due = 1'b0;
                    if (pixels_todo != 0) pixels_todo = pixels_todo - 21'd1;
                    exp_res.spi_byte = pixel_color[7:0];
                    // The last low byte closes the fill and releases select.
                    if (pixels_todo == 0) begin
                        stream_phase = PH_IDLE;
                        exp_res.release_select = 1'b1;
                        exp_res.fill_done = 1'b1;
                    end
                end
            end
            default: begin
                stream_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic t_req mk_fill(input int x, input int y, input int w, input int h,
                                     input int color);
        t_req it;
        it.kind        = KIND_FILL;
        it.origin_col  = 16'(x);
        it.origin_row  = 16'(y);
        it.rect_width  = 16'(w);
        it.rect_height = 16'(h);
        it.fill_color  = 16'(color);
        return it;
    endfunction

    // Tick with random payload; the payload is ignored by the block.
    function automatic t_req mk_tick();
        t_req it;
        it = mk_fill($urandom, $urandom, $urandom, $urandom, $urandom);
        it.kind = KIND_TICK;
        return it;
    endfunction

    // Random request that can never be accepted: one field is forced out of range.
    function automatic t_req mk_reject_fill();
        t_req it;
        it = mk_fill($urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 5))
            0: it.origin_col[15] = 1'b1;
            1: it.origin_row[15] = 1'b1;
            2: it.origin_col = 16'($urandom_range(MAX_SIDE_DEF, 32767));
            3: it.origin_row = 16'($urandom_range(MAX_SIDE_DEF, 32767));
            4: it.rect_width = 16'(0 - int'($urandom_range(0, 32768)));
            default: it.rect_height = 16'(0 - int'($urandom_range(0, 32768)));
        endcase
        return it;
    endfunction

    // Chooses an origin and size along one axis: near the origin with small sizes,
    // or near the far edge where oversized requests get clipped.
    function automatic void pick_axis(input logic [10:0] reg_size, output int origin,
                                      output int size);
        int span, k;
        span = (reg_size > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(reg_size);
        if (span == 0 || $urandom_range(0, 1) == 0) begin
            origin = $urandom_range(0, 3);
            size   = $urandom_range(1, 4);
        end else begin
            k      = $urandom_range(0, 3);
            origin = (span > k) ? span - 1 - k : 0;
            size   = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(5, 32767);
        end
    endfunction

    // Queues one random sequence and returns how many items it added. Most are a
    // fill followed by the ticks its stream needs, capped as if at most four by four
    // pixels, sometimes a few short or long, with refused requests mixed in.
    function automatic int queue_fill_sequence();
        int pick, x, y, w, h, n_ticks, pushed;
        pushed = 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            pick_axis(shadow_width, x, w);
            pick_axis(shadow_height, y, h);
            pending_items.push_back(mk_fill(x, y, w, h, $urandom));
            pushed = 1;
            n_ticks = 12 + 2 * ((w > 4) ? 4 : w) * ((h > 4) ? 4 : h);
            case ($urandom_range(0, 9))
                0: n_ticks = n_ticks - $urandom_range(1, 4);
                1: n_ticks = n_ticks + $urandom_range(1, 3);
                default: ;
            endcase
            repeat (n_ticks) begin
                if ($urandom_range(0, 99) < 8) begin
                    pending_items.push_back(mk_reject_fill());
                    pushed++;
                end
                pending_items.push_back(mk_tick());
                pushed++;
            end
        end else if (pick < 85) begin
            pending_items.push_back(mk_reject_fill());
            pushed = 1;
        end else begin
            repeat ($urandom_range(1, 3)) begin
                pending_items.push_back(mk_tick());
                pushed++;
            end
        end
        return pushed;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    // Request driver: offers the next pending item once the previous one transferred.
    always @(negedge i_clk) begin
        t_req it;
        if (!req_if.valid || req_fire) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                req_if.kind        <= it.kind;
                req_if.origin_col  <= it.origin_col;
                req_if.origin_row  <= it.origin_row;
                req_if.rect_width  <= it.rect_width;
                req_if.rect_height <= it.rect_height;
                req_if.fill_color  <= it.fill_color;
                req_if.valid       <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off when armed.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (stall_armed && !stall_done) begin
            stall_left   <= 80;
            stall_done   <= 1'b1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result transfer, then predicts from each request transfer.
    always @(posedge i_clk) begin
        t_req took;
        t_res exp_res;
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: status %0d, byte 0x%02h",
                           res_if.status, res_if.spi_byte);
                    errors++;
                end else begin
                    exp_res = results_due.pop_front();
                    check_field("status", exp_res.status, res_if.status);
                    check_field("spi_byte", exp_res.spi_byte, res_if.spi_byte);
                    check_field("is_data", exp_res.is_data, res_if.is_data);
                    check_field("release_select", exp_res.release_select,
                                res_if.release_select);
                    check_field("fill_done", exp_res.fill_done, res_if.fill_done);
                end
            end
            if (req_if.valid && req_if.ready) begin
                took.kind        = req_if.kind;
                took.origin_col  = req_if.origin_col;
                took.origin_row  = req_if.origin_row;
                took.rect_width  = req_if.rect_width;
                took.rect_height = req_if.rect_height;
                took.fill_color  = req_if.fill_color;
                if (predict_stream(took, exp_res)) results_due.push_back(exp_res);
            end
        end
    end

    // Writes one panel register over APB and reads it back.
    task automatic write_panel(input logic [0:0] idx, input logic [10:0] val);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_PANEL_WIDTH) shadow_width = val;
        else shadow_height = val;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        if (rd != {21'd0, val}) begin
            $error("register %0d readback mismatch: expected 0x%08h, actual 0x%08h",
                   idx, {21'd0, val}, rd);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued item has transferred and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || req_if.valid || results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Brings the block back to idle, ticking out any stream left unfinished.
    task automatic settle();
        wait_drained();
        while (stream_phase != PH_IDLE) begin
            repeat (16) pending_items.push_back(mk_tick());
            wait_drained();
        end
    endtask

    // One phase of random traffic under a given panel size and idling mix.
    task automatic run_phase(input logic [10:0] w, input logic [10:0] h, input int send_pct,
                             input int recv_pct, input int n_items, input bit hold_off);
        int queued;
        write_panel(REG_PANEL_WIDTH, w);
        write_panel(REG_PANEL_HEIGHT, h);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queued = 0;
        while (queued < n_items) queued += queue_fill_sequence();
        if (hold_off) stall_armed = 1'b1;
        settle();
    endtask

    // Main sequence.
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_TICK;
        req_if.origin_col  = '0;
        req_if.origin_row  = '0;
        req_if.rect_width  = '0;
        req_if.rect_height = '0;
        req_if.fill_color  = '0;
        res_if.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset panel size: off-screen and empty requests,
        // a single pixel in the far corner, and a request refused while busy.
        send_idle_pct = 30;
        recv_idle_pct = 57;
        pending_items.push_back(mk_tick());
        pending_items.push_back(mk_fill(-1, 0, 2, 2, 16'h1234));
        pending_items.push_back(mk_fill(0, -32768, 1, 1, 16'h0000));
        pending_items.push_back(mk_fill(240, 0, 1, 1, 16'hFFFF));
        pending_items.push_back(mk_fill(0, 320, 1, 1, 16'h8001));
        pending_items.push_back(mk_fill(32767, 32767, 32767, 32767, 16'hFFFF));
        pending_items.push_back(mk_fill(0, 0, 0, 5, 16'h5555));
        pending_items.push_back(mk_fill(0, 0, 5, -32768, 16'hAAAA));
        pending_items.push_back(mk_fill(239, 319, 1, 1, 16'hA5C3));
        pending_items.push_back(mk_tick());
        pending_items.push_back(mk_fill(0, 0, 1, 1, 16'h0F0F));
        repeat (13) pending_items.push_back(mk_tick());
        settle();

        // Random phases: receiver idles more first, then the sender, then neither.
        run_phase(11'd240, 11'd320, 30, 57, 120, 1'b0);
        run_phase(11'd1024, 11'd1024, 30, 57, 120, 1'b0);
        run_phase(11'd2047, 11'd2047, 30, 57, 120, 1'b0);
        run_phase(11'd1, 11'd1, 57, 30, 120, 1'b0);
        run_phase(11'd0, 11'd320, 57, 30, 50, 1'b0);
        run_phase(11'd240, 11'd0, 57, 30, 50, 1'b0);
        run_phase(11'd7, 11'd5, 0, 0, 120, 1'b0);
        run_phase(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), 0, 0, 120, 1'b1);
        run_phase(11'd1024, 11'd1, 0, 0, 120, 1'b0);

        if (errors == 0) begin
            $display("** lcd_rect_fill_streamer_top: PASSED **");
        end else begin
            $display("** lcd_rect_fill_streamer_top: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("** lcd_rect_fill_streamer_top: FAILED **");
        $finish;
    end

endmodule

### lcd_rect_fill_streamer_top.f
sv/lrf_pkg.sv
sv/lrf_if.sv
sv/lrf_cfg_regs.sv
sv/lrf_clip.sv
sv/lrf_engine.sv
sv/lcd_rect_fill_streamer_top.sv
tb/lcd_rect_fill_streamer_top_tb.sv
